/* rtl/core/btd_pkg.sv */
// Shared types, constants and filter coefficients of the breath trigger detector.
package btd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned APNEA_LIMIT_DEF = 15000;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned REG17_W  = 17;
  localparam int unsigned TPER_W   = 16;
  localparam int unsigned UNLOCK_W = 32;
  localparam int unsigned X_W      = 18;
  localparam int unsigned Y_W      = 25;
  localparam int unsigned ACC_W    = 42;
  localparam int unsigned TIME_W   = 14;
  localparam int unsigned HOLD_W   = 11;
  localparam int unsigned PERIOD_W = 13;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned DIV_SHIFT  = 13;
  localparam int unsigned GAIN_SHIFT = 5;

  localparam logic [HOLD_W-1:0]   HOLDOFF_TICKS  = 11'd1500;
  localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 13'd3000;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN     = 13'd1500;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 13'd7500;
  localparam logic [UNLOCK_W-1:0] UNLOCK_KEY     = 32'h2B4E_E0F9;

  // Feed-forward taps on the inputs and feedback taps on the outputs.
  localparam logic signed [ACC_W-1:0] COEF_B0 = 42'sd130;
  localparam logic signed [ACC_W-1:0] COEF_B1 = -42'sd112;
  localparam logic signed [ACC_W-1:0] COEF_B2 = -42'sd112;
  localparam logic signed [ACC_W-1:0] COEF_B3 = 42'sd130;
  localparam logic signed [ACC_W-1:0] COEF_A1 = -42'sd23982;
  localparam logic signed [ACC_W-1:0] COEF_A2 = 42'sd23433;
  localparam logic signed [ACC_W-1:0] COEF_A3 = -42'sd7642;

  localparam logic signed [ACC_W-1:0] Y_MAX = 42'sd16777215;
  localparam logic signed [ACC_W-1:0] Y_MIN = -42'sd16777216;

  typedef enum logic [1:0] {
    REG_BASELINE    = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_TEST_PERIOD = 2'd2,
    REG_TEST_UNLOCK = 2'd3
  } btd_reg_e;

endpackage

/* rtl/core/btd_in_if.sv */
// Input channel carrying one raw pressure sample per item.
interface btd_in_if;
  logic                      valid;
  logic                      ready;
  logic [btd_pkg::RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

/* rtl/core/btd_out_if.sv */
// Output channel carrying one detection result per item.
interface btd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                breath_seen;
  logic [btd_pkg::TIME_W-1:0]          elapsed_ms;
  logic [btd_pkg::PERIOD_W-1:0]        report_period;
  logic                                apnea_alarm;
  logic signed [btd_pkg::Y_W-1:0]      filtered_pressure;

  modport source (output valid, output breath_seen, output elapsed_ms, output report_period,
                  output apnea_alarm, output filtered_pressure, input ready);
  modport sink   (input valid, input breath_seen, input elapsed_ms, input report_period,
                  input apnea_alarm, input filtered_pressure, output ready);
endinterface

/* rtl/core/breath_trigger_detector.sv */
// Breath trigger detector: offset removal, third-order IIR low-pass, trigger, holdoff, apnea.
//
// Each input item is one raw pressure sample, nominally one per millisecond. The block
// subtracts the zero offset, runs the sample through a fixed third-order direct form I
// low-pass filter (DC gain of 36, result floored by 2^13 and saturated to 25 bits) and fires
// a breath when the filtered value is at or below the trigger level times 32; with test
// mode unlocked and a nonzero test period, it instead fires when elapsed time reaches that
// period. After reset and after each breath, 1500 samples pass before a new breath can be
// reported. Every sample yields exactly one result item; on a breath it carries the raw
// elapsed time and the period clamped to 1500..7500 ms (longer periods report 3000). The
// apnea alarm rises once APNEA_LIMIT samples pass without a breath and clears on the next
// breath. The block has a two-stage pipeline: an input register holding the offset-corrected
// sample and a result register. The filter, trigger and counter update run combinationally
// between them, because the filter feedback and counters of one item must be settled before
// the next, so a new item is accepted every cycle while the output takes results without
// stalling. An accepted item moves from the input register into the result register. While
// a result waits, one more sample can be held in the input register; only once that register
// is also full does the input stop accepting. Configuration is written over the APB port at
// byte addresses 0 (zero offset), 4 (trigger level), 8 (test period) and 12 (test unlock
// word), and must only be changed while the block holds no item.
module breath_trigger_detector #(
  parameter int unsigned SAMPLE_BITS = btd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned APNEA_LIMIT = btd_pkg::APNEA_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  btd_in_if.sink                      in_if,
  btd_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [btd_pkg::ADDR_W-1:0]  paddr,
  input  logic [btd_pkg::DATA_W-1:0]  pwdata,
  output logic [btd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam logic [btd_pkg::RAW_W-1:0] RawMask =
    btd_pkg::RAW_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [btd_pkg::TIME_W-1:0] ApneaLim = btd_pkg::TIME_W'(APNEA_LIMIT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [btd_pkg::REG17_W-1:0] baseline_q;
  logic signed [btd_pkg::REG17_W-1:0] threshold_q;
  logic [btd_pkg::TPER_W-1:0]         test_period_q;
  logic [btd_pkg::UNLOCK_W-1:0]       test_unlock_q;
  logic                               cfg_wr;
  btd_pkg::btd_reg_e                  reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = btd_pkg::btd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q    <= '0;
      threshold_q   <= '0;
      test_period_q <= '0;
      test_unlock_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        btd_pkg::REG_BASELINE:    baseline_q    <= pwdata[btd_pkg::REG17_W-1:0];
        btd_pkg::REG_THRESHOLD:   threshold_q   <= pwdata[btd_pkg::REG17_W-1:0];
        btd_pkg::REG_TEST_PERIOD: test_period_q <= pwdata[btd_pkg::TPER_W-1:0];
        btd_pkg::REG_TEST_UNLOCK: test_unlock_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      btd_pkg::REG_BASELINE:    prdata = btd_pkg::DATA_W'(unsigned'(baseline_q));
      btd_pkg::REG_THRESHOLD:   prdata = btd_pkg::DATA_W'(unsigned'(threshold_q));
      btd_pkg::REG_TEST_PERIOD: prdata = btd_pkg::DATA_W'(test_period_q);
      btd_pkg::REG_TEST_UNLOCK: prdata = test_unlock_q;
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: offset-corrected sample
  // ---------------------------------------------------------------------------
  logic                           s1_valid_q;
  logic signed [btd_pkg::X_W-1:0] x_q;
  logic signed [btd_pkg::X_W-1:0] x_d;
  logic [btd_pkg::RAW_W-1:0]      raw_masked;
  logic                           in_fire;
  logic                           step;
  logic                           out_valid_q;

  assign raw_masked = in_if.raw_sample & RawMask;
  assign x_d = $signed({2'b00, raw_masked}) -
               btd_pkg::X_W'(baseline_q);

  // The sample in the input register moves on whenever the result register is free
  // or is being emptied in this cycle.
  assign step        = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || step;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= x_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Filter, trigger and counters
  // ---------------------------------------------------------------------------
  logic signed [btd_pkg::X_W-1:0] x_hist_q [3];
  logic signed [btd_pkg::Y_W-1:0] y_hist_q [3];
  logic [btd_pkg::TIME_W-1:0]     time_q, time_d;
  logic [btd_pkg::HOLD_W-1:0]     holdoff_q, holdoff_d;
  logic                           apnea_q, apnea_d;

  logic signed [btd_pkg::ACC_W-1:0] acc;
  logic signed [btd_pkg::ACC_W-1:0] acc_q13;
  logic signed [btd_pkg::Y_W-1:0]   y;
  logic signed [btd_pkg::Y_W-1:0]   level_scaled;
  logic [btd_pkg::TIME_W:0]         time_inc;
  logic [btd_pkg::TIME_W-1:0]       time_sat;
  logic                             test_mode;
  logic                             trig;
  logic                             seen;
  logic [btd_pkg::TIME_W-1:0]       elapsed;
  logic [btd_pkg::PERIOD_W-1:0]     period;

  always_comb begin
    acc = btd_pkg::COEF_B0 * btd_pkg::ACC_W'(x_q)
        + btd_pkg::COEF_B1 * btd_pkg::ACC_W'(x_hist_q[0])
        + btd_pkg::COEF_B2 * btd_pkg::ACC_W'(x_hist_q[1])
        + btd_pkg::COEF_B3 * btd_pkg::ACC_W'(x_hist_q[2])
        - btd_pkg::COEF_A1 * btd_pkg::ACC_W'(y_hist_q[0])
        - btd_pkg::COEF_A2 * btd_pkg::ACC_W'(y_hist_q[1])
        - btd_pkg::COEF_A3 * btd_pkg::ACC_W'(y_hist_q[2]);
    // Arithmetic shift floors toward minus infinity.
    acc_q13 = acc >>> btd_pkg::DIV_SHIFT;
    if (acc_q13 > btd_pkg::Y_MAX) begin
      y = btd_pkg::Y_W'(btd_pkg::Y_MAX);
    end else if (acc_q13 < btd_pkg::Y_MIN) begin
      y = btd_pkg::Y_W'(btd_pkg::Y_MIN);
    end else begin
      y = acc_q13[btd_pkg::Y_W-1:0];
    end
  end

  always_comb begin
    level_scaled = btd_pkg::Y_W'(threshold_q) <<< btd_pkg::GAIN_SHIFT;
    time_inc     = {1'b0, time_q} + 1'b1;
    time_sat     = (time_inc > {1'b0, ApneaLim}) ? ApneaLim
                                                 : time_inc[btd_pkg::TIME_W-1:0];
    test_mode    = (test_period_q != '0) && (test_unlock_q == btd_pkg::UNLOCK_KEY);
    trig         = test_mode ? ({2'b00, time_sat} >= test_period_q) : (y <= level_scaled);

    seen      = 1'b0;
    elapsed   = '0;
    period    = '0;
    time_d    = time_sat;
    holdoff_d = holdoff_q;
    apnea_d   = apnea_q;

    if (holdoff_q != '0) begin
      holdoff_d = holdoff_q - 1'b1;
    end else if (trig) begin
      seen    = 1'b1;
      elapsed = time_sat;
      if (time_sat > btd_pkg::TIME_W'(btd_pkg::PERIOD_MAX)) begin
        period = btd_pkg::PERIOD_DEFAULT;
      end else if (time_sat < btd_pkg::TIME_W'(btd_pkg::PERIOD_MIN)) begin
        period = btd_pkg::PERIOD_MIN;
      end else begin
        period = time_sat[btd_pkg::PERIOD_W-1:0];
      end
      apnea_d   = 1'b0;
      holdoff_d = btd_pkg::HOLDOFF_TICKS;
      time_d    = '0;
    end

    if (time_d >= ApneaLim) begin
      apnea_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_hist_q  <= '{default: '0};
      y_hist_q  <= '{default: '0};
      time_q    <= '0;
      holdoff_q <= btd_pkg::HOLDOFF_TICKS;
      apnea_q   <= 1'b0;
    end else if (step) begin
      x_hist_q[2] <= x_hist_q[1];
      x_hist_q[1] <= x_hist_q[0];
      x_hist_q[0] <= x_q;
      y_hist_q[2] <= y_hist_q[1];
      y_hist_q[1] <= y_hist_q[0];
      y_hist_q[0] <= y;
      time_q      <= time_d;
      holdoff_q   <= holdoff_d;
      apnea_q     <= apnea_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                             seen_q;
  logic [btd_pkg::TIME_W-1:0]       elapsed_q;
  logic [btd_pkg::PERIOD_W-1:0]     period_q;
  logic                             alarm_q;
  logic signed [btd_pkg::Y_W-1:0]   y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      seen_q    <= seen;
      elapsed_q <= elapsed;
      period_q  <= period;
      alarm_q   <= apnea_d;
      y_q       <= y;
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.breath_seen       = seen_q;
  assign out_if.elapsed_ms        = elapsed_q;
  assign out_if.report_period     = period_q;
  assign out_if.apnea_alarm       = alarm_q;
  assign out_if.filtered_pressure = y_q;

endmodule

/* rtl/core/btd_checker.sv */
// Port-level checks of the breath trigger detector and the bind that attaches them.
module btd_checker #(
  parameter int unsigned APNEA_LIMIT = btd_pkg::APNEA_LIMIT_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          breath_seen,
  input logic [btd_pkg::TIME_W-1:0]    elapsed_ms,
  input logic [btd_pkg::PERIOD_W-1:0]  report_period,
  input logic                          apnea_alarm,
  input logic signed [btd_pkg::Y_W-1:0] filtered_pressure
);

  // A stalled result item stays on the port; all its fields but the apnea alarm are checked unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(elapsed_ms) && $stable(report_period)
      && $stable(breath_seen) && $stable(filtered_pressure))
    else $error("result item changed while stalled");

  // Without a breath the timing fields read zero.
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !breath_seen |-> elapsed_ms == '0 && report_period == '0)
    else $error("timing fields nonzero without a breath");

  // A breath clears the alarm and reports a clamped period.
  a_breath_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && breath_seen |-> !apnea_alarm
      && report_period >= btd_pkg::PERIOD_MIN && report_period <= btd_pkg::PERIOD_MAX)
    else $error("breath item with alarm set or period out of range");

  // Holdoff keeps breaths apart, and elapsed time never passes the apnea limit.
  a_breath_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && breath_seen |-> elapsed_ms > btd_pkg::TIME_W'(btd_pkg::HOLDOFF_TICKS)
      && elapsed_ms <= btd_pkg::TIME_W'(APNEA_LIMIT))
    else $error("breath elapsed time outside holdoff and apnea bounds");

endmodule

bind breath_trigger_detector btd_checker #(
  .APNEA_LIMIT(APNEA_LIMIT)
) u_btd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .breath_seen       (out_if.breath_seen),
  .elapsed_ms        (out_if.elapsed_ms),
  .report_period     (out_if.report_period),
  .apnea_alarm       (out_if.apnea_alarm),
  .filtered_pressure (out_if.filtered_pressure)
);
